/* sv/playfair_digraph_cipher_core_defines.svh */
// Assertion macros shared by the Playfair cipher RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PFC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define PFC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pfc_pkg.sv */
// Types, constants and square arithmetic for the Playfair cipher core.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_X = 5'd23;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_MSG    = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_FINISH = 2'd1,
        OP_PAIR   = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        letter_t  a;
        letter_t  b;
    } op_t;

    typedef struct packed {
        letter_t letter;
        logic    last;
    } res_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FILL,
        BS_LOOKUP,
        BS_OUT_FIRST,
        BS_OUT_SECOND
    } back_state_t;

    function automatic letter_t fold_letter(letter_t l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic coord_t cell_row(cell_t c);
        coord_t r;
        r = '0;
        for (int i = 1; i < SQUARE_SIDE; i++) begin
            if (c >= cell_t'(i * SQUARE_SIDE)) begin
                r = coord_t'(i);
            end
        end
        return r;
    endfunction

    function automatic cell_t cell_at(coord_t r, coord_t c);
        return cell_t'(r) * cell_t'(SQUARE_SIDE) + cell_t'(c);
    endfunction

    function automatic coord_t cell_col(cell_t c);
        return coord_t'(c - cell_at(cell_row(c), '0));
    endfunction

    // Move one place along a row or column, wrapping at the square edge.
    function automatic coord_t step_coord(coord_t c, logic fwd);
        coord_t n;
        if (fwd) begin
            n = (c == coord_t'(SQUARE_SIDE - 1)) ? '0 : c + 3'd1;
        end
        else begin
            n = (c == '0) ? coord_t'(SQUARE_SIDE - 1) : c - 3'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* sv/pfc_fifo.sv */
// Small synchronous FIFO used for the operation queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_core_defines.svh"
module pfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `PFC_ASSERT_ALWAYS(a_fifo_count_bound, count_reg <= (AW + 1)'(DEPTH), "FIFO count exceeds depth")
    `PFC_ASSERT_ALWAYS(a_fifo_full_empty, !(full && empty), "FIFO full and empty at once")
    `PFC_ASSERT_NEXT(a_fifo_grow, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "FIFO count did not grow on a lone push")

endmodule
`default_nettype wire

/* sv/pfc_front.sv */
// Front end: accepts command beats, folds letters and pairs message letters.
`timescale 1ns / 1ps
`default_nettype none
module pfc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [1:0]     cmd,
    input  logic [4:0]     letter,
    output logic           full,
    output logic           op_push,
    output pfc_pkg::op_t   op_data,
    input  logic           op_full
);
    import pfc_pkg::*;

    logic    pending_valid_reg, pending_valid_next;
    letter_t pending_letter_reg, pending_letter_next;
    logic    accept;
    logic    letter_ok;
    letter_t folded;

    assign full      = op_full;
    assign accept    = push && !op_full;
    assign letter_ok = (letter < 5'(LETTERS));
    assign folded    = fold_letter(letter);

    always_comb
    begin
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        op_push             = 1'b0;
        op_data.kind        = OP_KEY;
        op_data.a           = folded;
        op_data.b           = LETTER_X;
        if (accept) begin
            unique case (cmd_t'(cmd))
                CMD_KEY:
                begin
                    op_push = letter_ok;
                end
                CMD_FINISH:
                begin
                    op_push      = 1'b1;
                    op_data.kind = OP_FINISH;
                end
                CMD_MSG:
                begin
                    if (letter_ok) begin
                        if (!pending_valid_reg) begin
                            pending_valid_next  = 1'b1;
                            pending_letter_next = folded;
                        end
                        else begin
                            // A doubled letter becomes x in second place.
                            op_push            = 1'b1;
                            op_data.kind       = OP_PAIR;
                            op_data.a          = pending_letter_reg;
                            op_data.b          = (folded == pending_letter_reg) ?
                                                 LETTER_X : folded;
                            pending_valid_next = 1'b0;
                        end
                    end
                end
                CMD_END:
                begin
                    if (pending_valid_reg) begin
                        op_push            = 1'b1;
                        op_data.kind       = OP_PAIR;
                        op_data.a          = pending_letter_reg;
                        op_data.b          = LETTER_X;
                        pending_valid_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
        end
        else begin
            pending_valid_reg  <= pending_valid_next;
            pending_letter_reg <= pending_letter_next;
        end
    end

endmodule
`default_nettype wire

/* sv/pfc_back.sv */
// Back end: builds the key square and enciphers letter pairs.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_core_defines.svh"
module pfc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           encrypt_mode,
    input  logic           op_empty,
    input  pfc_pkg::op_t   op_data,
    output logic           op_pop,
    input  logic           res_full,
    output logic           res_push,
    output pfc_pkg::res_t  res_data
);
    import pfc_pkg::*;

    back_state_t state_reg, state_next;
    cell_t       fill_count_reg, fill_count_next;
    letter_t     walk_reg, walk_next;
    logic [LETTERS-1:0] used_reg, used_next;

    letter_t square_mem [CELLS];
    cell_t   pos_mem [LETTERS];
    cell_t   pos_a_reg, pos_b_reg;
    letter_t sq_a_reg, sq_b_reg;

    logic    place_try, place_ok, pos_rd_en, sq_rd_en;
    letter_t place_letter;
    coord_t  ra, ca, rb, cb;
    logic    same_row, same_col;
    cell_t   na, nb;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (!op_empty) begin
                    unique case (op_data.kind)
                        OP_FINISH: state_next = BS_FILL;
                        OP_PAIR:   state_next = BS_LOOKUP;
                        default:   state_next = BS_IDLE;
                    endcase
                end
            end
            BS_FILL:
            begin
                if (walk_reg == 5'(LETTERS - 1)) begin
                    state_next = BS_IDLE;
                end
            end
            BS_LOOKUP:    state_next = BS_OUT_FIRST;
            BS_OUT_FIRST:
            begin
                if (!res_full) begin
                    state_next = BS_OUT_SECOND;
                end
            end
            BS_OUT_SECOND:
            begin
                if (!res_full) begin
                    state_next = BS_IDLE;
                end
            end
            default:      state_next = BS_IDLE;
        endcase
    end

    // Outputs and datapath controls.
    always_comb
    begin
        op_pop          = 1'b0;
        res_push        = 1'b0;
        res_data.letter = sq_a_reg;
        res_data.last   = 1'b0;
        place_try       = 1'b0;
        place_letter    = op_data.a;
        pos_rd_en       = 1'b0;
        sq_rd_en        = 1'b0;
        walk_next       = '0;
        unique case (state_reg)
            BS_IDLE:
            begin
                op_pop = !op_empty;
                if (!op_empty) begin
                    place_try = (op_data.kind == OP_KEY);
                    pos_rd_en = (op_data.kind == OP_PAIR);
                end
            end
            BS_FILL:
            begin
                place_letter = walk_reg;
                place_try    = (walk_reg != LETTER_J);
                walk_next    = walk_reg + 5'd1;
            end
            BS_LOOKUP:
            begin
                sq_rd_en = 1'b1;
            end
            BS_OUT_FIRST:
            begin
                res_push = !res_full;
            end
            BS_OUT_SECOND:
            begin
                res_push        = !res_full;
                res_data.letter = sq_b_reg;
                res_data.last   = 1'b1;
            end
            default:
            begin
                op_pop = 1'b0;
            end
        endcase
    end

    // A letter goes into the next free cell once, while the square has room.
    always_comb
    begin
        place_ok        = place_try && !used_reg[place_letter] &&
                          (fill_count_reg < 5'(CELLS));
        used_next       = used_reg;
        fill_count_next = fill_count_reg;
        if (place_ok) begin
            used_next[place_letter] = 1'b1;
            fill_count_next         = fill_count_reg + 5'd1;
        end
    end

    // Pair rule: row shift, column shift or rectangle swap.
    always_comb
    begin
        ra       = cell_row(pos_a_reg);
        ca       = cell_col(pos_a_reg);
        rb       = cell_row(pos_b_reg);
        cb       = cell_col(pos_b_reg);
        same_row = (ra == rb);
        same_col = (ca == cb);
        if (same_row) begin
            na = cell_at(ra, step_coord(ca, encrypt_mode));
            nb = cell_at(rb, step_coord(cb, encrypt_mode));
        end
        else if (same_col) begin
            na = cell_at(step_coord(ra, encrypt_mode), ca);
            nb = cell_at(step_coord(rb, encrypt_mode), cb);
        end
        else begin
            na = cell_at(ra, cb);
            nb = cell_at(rb, ca);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= BS_IDLE;
            fill_count_reg <= '0;
            walk_reg       <= '0;
            used_reg       <= '0;
        end
        else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            walk_reg       <= walk_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_ok) begin
            square_mem[fill_count_reg] <= place_letter;
            pos_mem[place_letter]      <= fill_count_reg;
        end
        if (pos_rd_en) begin
            pos_a_reg <= pos_mem[op_data.a];
            pos_b_reg <= pos_mem[op_data.b];
        end
        if (sq_rd_en) begin
            sq_a_reg <= square_mem[na];
            sq_b_reg <= square_mem[nb];
        end
    end

    `PFC_ASSERT_ALWAYS(a_fill_bound, fill_count_reg <= 5'(CELLS), "Square fill count exceeds cell count")
    `PFC_ASSERT_ALWAYS(a_used_matches_fill, $countones(used_reg) == int'(fill_count_reg), "Used letters disagree with fill count")
    `PFC_ASSERT_NEXT(a_fill_step, 1'b1, (fill_count_reg == $past(fill_count_reg)) || (fill_count_reg == $past(fill_count_reg) + 5'd1), "Fill count moved by more than one")
    `PFC_ASSERT_IMPLY(a_walk_range, state_reg == BS_FILL, walk_reg < 5'(LETTERS), "Alphabet walk past last letter")

endmodule
`default_nettype wire

/* sv/playfair_digraph_cipher_core.sv */
// Top level of the Playfair digraph cipher core.
// Usage: the block looks like a queue on both sides. A command beat (cmd, letter)
// is taken on a clock edge with push high and full low. cmd 0 adds a key letter,
// cmd 1 completes the 5x5 square with the unused alphabet, cmd 2 feeds a message
// letter and cmd 3 ends the message, padding a lone letter with x. Letters above
// 25 are dropped, and j is treated as i.
// Results leave as beats (out_letter, last_of_pair): the oldest one is shown while
// empty is low and is taken on an edge with pop high. Each letter pair gives two
// beats, the second marked by last_of_pair.
// Flow: the front stage classifies a beat in its accept cycle and queues an
// operation. The back end places a key letter as it pops it, finishes the key by
// walking the alphabet one letter per cycle, and runs a pair as a position read,
// a square read and its two result beats, each held while the result queue is full.
// It takes one operation at a time, while the front end fills the operation queue.
// Reset clears the square bookkeeping, the pending letter and both queues, and sets
// encrypt_mode to 1. The mode must be written via cfg_we/cfg_wdata only while idle;
// the block does not enforce it. A stalled receiver fills the result queue; the
// back end then waits, the operation queue fills, and full rises until pop frees
// space.
`timescale 1ns / 1ps
`default_nettype none
module playfair_digraph_cipher_core #(
    parameter int OP_DEPTH  = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] cmd,
    input  logic [4:0] letter,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] out_letter,
    output logic       last_of_pair,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import pfc_pkg::*;

    logic encrypt_mode_reg;
    logic op_push, op_full, op_empty, op_pop;
    op_t  op_in, op_out;
    logic res_push, res_full;
    res_t res_in, res_out;

    // The single configuration register: 1 encrypts, 0 decrypts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            encrypt_mode_reg <= 1'b1;
        end
        else if (cfg_we) begin
            encrypt_mode_reg <= cfg_wdata;
        end
    end

    // The front end owns the message pairing, so it never waits on the square.
    pfc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd     (cmd),
        .letter  (letter),
        .full    (full),
        .op_push (op_push),
        .op_data (op_in),
        .op_full (op_full)
    );

    // Operation queue decouples the front end from the back end.
    pfc_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (OP_DEPTH)
    ) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_in),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (op_out),
        .empty (op_empty)
    );

    pfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .encrypt_mode (encrypt_mode_reg),
        .op_empty     (op_empty),
        .op_data      (op_out),
        .op_pop       (op_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_data     (res_in)
    );

    // Result queue keeps the back end running while the receiver stalls briefly.
    pfc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign out_letter   = res_out.letter;
    assign last_of_pair = res_out.last;

endmodule
`default_nettype wire

/* tb/sv/tb_playfair_digraph_cipher_core.sv */
// Self-checking testbench for the Playfair digraph cipher core with its own cipher predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_playfair_digraph_cipher_core;
    import pfc_pkg::*;

    localparam int RESET_CYCLES  = 11;
    // A finish-key pass walks the whole alphabet and up to four operations can sit in
    // the operation queue, so this covers anything still in flight that gives no beat.
    localparam int DRAIN_CYCLES  = 150;
    // Longest quiet stretch of a correct run is the drain above plus a few stalls.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 230;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] cmd;
    logic [4:0] letter;
    logic       empty;
    logic       pop;
    logic [4:0] out_letter;
    logic       last_of_pair;
    logic       cfg_we;
    logic       cfg_wdata;

    // Cipher predictor state: the key square, where each letter sits in it, which
    // letters are already placed, how many cells are filled, the half-pair waiting
    // for its partner, and the current direction.
    letter_t key_square [CELLS];
    cell_t   square_cell_of [LETTERS];
    bit      letter_placed [LETTERS];
    int      square_fill;
    letter_t held_letter;
    bit      held_valid;
    bit      mode_encrypt;

    // Cipher beats predicted but not yet seen on the result side, oldest first.
    res_t    cipher_beats_due [$];

    int      error_count;
    int      stall_cycles;
    bit      idle_on;

    playfair_digraph_cipher_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .letter       (letter),
        .empty        (empty),
        .pop          (pop),
        .out_letter   (out_letter),
        .last_of_pair (last_of_pair),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Adds a letter to the next free cell unless it is out of range, already in
    // the square, or the square is complete.
    function automatic void place_key_letter(letter_t l);
        if (l < LETTERS && !letter_placed[l] && square_fill < CELLS)
        begin
            key_square[square_fill] = l;
            square_cell_of[l] = cell_t'(square_fill);
            letter_placed[l] = 1'b1;
            square_fill++;
        end
    endfunction

    // Appends one predicted beat behind those already waiting.
    function automatic void add_due_beat(res_t beat);
        cipher_beats_due = {cipher_beats_due, beat};
    endfunction

    // Predicts the two beats of one letter pair and queues them.
    function automatic void queue_cipher_pair(letter_t first, letter_t second);
        int   row_a;
        int   col_a;
        int   row_b;
        int   col_b;
        int   new_a;
        int   new_b;
        int   shift;
        res_t beat;
        row_a = int'(square_cell_of[first]) / SQUARE_SIDE;
        col_a = int'(square_cell_of[first]) % SQUARE_SIDE;
        row_b = int'(square_cell_of[second]) / SQUARE_SIDE;
        col_b = int'(square_cell_of[second]) % SQUARE_SIDE;
        // Moving back by one is the same as moving forward by side minus one.
        shift = mode_encrypt ? 1 : SQUARE_SIDE - 1;
        if (row_a == row_b)
        begin
            new_a = row_a * SQUARE_SIDE + (col_a + shift) % SQUARE_SIDE;
            new_b = row_b * SQUARE_SIDE + (col_b + shift) % SQUARE_SIDE;
        end
        else if (col_a == col_b)
        begin
            new_a = ((row_a + shift) % SQUARE_SIDE) * SQUARE_SIDE + col_a;
            new_b = ((row_b + shift) % SQUARE_SIDE) * SQUARE_SIDE + col_b;
        end
        else
        begin
            // Opposite corners of the rectangle: each letter keeps its row and
            // takes the other letter's column.
            new_a = row_a * SQUARE_SIDE + col_b;
            new_b = row_b * SQUARE_SIDE + col_a;
        end
        beat.letter = key_square[new_a];
        beat.last   = 1'b0;
        add_due_beat(beat);
        beat.letter = key_square[new_b];
        beat.last   = 1'b1;
        add_due_beat(beat);
    endfunction

    // Advances the predictor by one accepted command beat.
    function automatic void cipher_step(cmd_t c, letter_t l);
        letter_t folded;
        folded = (l == LETTER_J) ? LETTER_I : l;
        case (c)
            CMD_KEY:
            begin
                if (l < LETTERS)
                    place_key_letter(folded);
            end
            CMD_FINISH:
            begin
                for (int k = 0; k < LETTERS; k++)
                begin
                    if (k != LETTER_J)
                        place_key_letter(letter_t'(k));
                end
            end
            CMD_MSG:
            begin
                if (l < LETTERS)
                begin
                    if (!held_valid)
                    begin
                        held_letter = folded;
                        held_valid  = 1'b1;
                    end
                    else
                    begin
                        // A doubled letter is split by replacing the second with x.
                        held_valid = 1'b0;
                        queue_cipher_pair(held_letter,
                                          (folded == held_letter) ? LETTER_X : folded);
                    end
                end
            end
            default:
            begin
                // End of message pads a lone letter with x; with none held it is silent.
                if (held_valid)
                begin
                    held_valid = 1'b0;
                    queue_cipher_pair(held_letter, LETTER_X);
                end
            end
        endcase
    endfunction

    // Offers one command beat, holding it until the block takes it. A random idle
    // burst may come first while idling is enabled.
    task automatic send_beat(cmd_t c, letter_t l);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push   <= 1'b1;
        cmd    <= c;
        letter <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        cipher_step(c, l);
    endtask

    task automatic send_cell_pair(int cell_a, int cell_b);
        send_beat(CMD_MSG, key_square[cell_a]);
        send_beat(CMD_MSG, key_square[cell_b]);
    endtask

    // Waits until every predicted beat has come out and the back end has had time
    // to finish silent work, then writes the direction register.
    task automatic settle_and_set_mode(bit encrypt);
        push <= 1'b0;
        while (cipher_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= encrypt;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_encrypt = encrypt;
    endtask

    // Builds the one square of the run. Exercises the j to i fold, a repeated key
    // letter, out-of-range letters, both end letters of the alphabet, and beats sent
    // to a complete square. Before the square is complete only beats that read
    // nothing from it are sent.
    task automatic test_key_square();
        send_beat(CMD_KEY, 5'd25);
        send_beat(CMD_KEY, LETTER_J);
        send_beat(CMD_KEY, LETTER_I);
        send_beat(CMD_KEY, 5'd31);
        send_beat(CMD_KEY, 5'd0);
        repeat (2) send_beat(CMD_KEY, letter_t'($urandom_range(0, 31)));
        send_beat(CMD_MSG, 5'd26);
        send_beat(CMD_END, letter_t'($urandom));
        send_beat(CMD_FINISH, letter_t'($urandom));
        send_beat(CMD_KEY, 5'd11);
        send_beat(CMD_FINISH, 5'd0);
    endtask

    // One example of each pair rule in encrypt mode, with wraps at the square edge.
    task automatic test_pair_rules();
        int r;
        int c;
        r = $urandom_range(0, SQUARE_SIDE - 1);
        c = $urandom_range(0, SQUARE_SIDE - 1);
        // Same row, first letter in the last column so its shift wraps.
        send_cell_pair(r * SQUARE_SIDE + SQUARE_SIDE - 1, r * SQUARE_SIDE);
        // Same column, first letter in the bottom row.
        send_cell_pair((SQUARE_SIDE - 1) * SQUARE_SIDE + c, c);
        // Opposite corners of the square.
        send_cell_pair(0, CELLS - 1);
        // j folds to i, which then repeats the held i and becomes x.
        send_beat(CMD_MSG, LETTER_J);
        send_beat(CMD_MSG, LETTER_I);
        // An out-of-range letter between the halves of a pair is dropped.
        send_beat(CMD_MSG, key_square[$urandom_range(0, CELLS - 1)]);
        send_beat(CMD_MSG, 5'd29);
        send_beat(CMD_MSG, key_square[$urandom_range(0, CELLS - 1)]);
        // A held x padded with x lands in its own row.
        send_beat(CMD_MSG, LETTER_X);
        send_beat(CMD_END, 5'd0);
        // End with nothing held gives no beat.
        send_beat(CMD_END, 5'd31);
    endtask

    // Random message traffic in several phases, each with its own direction. Most
    // beats are message letters, often chosen to share a row or column with the
    // held letter, to repeat it, or to be x; a few are ends and a few are noise the
    // block drops. The last phase and one in the middle run without idling.
    task automatic test_random_messages();
        int      counted;
        int      roll;
        int      pick;
        int      held_cell;
        letter_t l;
        cmd_t    c;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                settle_and_set_mode(1'b0);
            else if (phase == 1)
                settle_and_set_mode(1'b1);
            else
                settle_and_set_mode($urandom_range(0, 1) == 1);
            idle_on = (phase != RANDOM_PHASES - 1) && (phase != 3);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                begin
                    pick = $urandom_range(0, 2);
                    c = (pick == 0) ? CMD_KEY : (pick == 1) ? CMD_FINISH : CMD_MSG;
                    if (c == CMD_MSG)
                        l = letter_t'($urandom_range(LETTERS, 31));
                    else
                        l = letter_t'($urandom);
                end
                else if (roll < 13)
                begin
                    c = CMD_END;
                    l = letter_t'($urandom);
                    if (held_valid)
                        counted++;
                end
                else
                begin
                    c = CMD_MSG;
                    l = letter_t'($urandom_range(0, LETTERS - 1));
                    counted++;
                    if (held_valid && $urandom_range(0, 3) != 0)
                    begin
                        held_cell = int'(square_cell_of[held_letter]);
                        case ($urandom_range(0, 4))
                            0: l = key_square[(held_cell / SQUARE_SIDE) * SQUARE_SIDE
                                              + $urandom_range(0, SQUARE_SIDE - 1)];
                            1: l = key_square[$urandom_range(0, SQUARE_SIDE - 1) * SQUARE_SIDE
                                              + held_cell % SQUARE_SIDE];
                            2: l = (held_letter == LETTER_I) ? LETTER_J : held_letter;
                            3: l = LETTER_X;
                            default: ;
                        endcase
                    end
                end
                send_beat(c, l);
            end
        end
    endtask

    // Result side: pop stays high apart from random stall bursts while idling is on.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    // Every beat taken from the block is matched against the oldest prediction.
    always @(posedge clk)
    begin : beat_check
        res_t due;
        if (rst_n && pop && !empty)
        begin
            if (cipher_beats_due.size() == 0)
            begin
                $error("out_letter: no beat expected, got %0d", out_letter);
                error_count++;
            end
            else
            begin
                due = cipher_beats_due.pop_front();
                if (out_letter !== due.letter)
                begin
                    $error("out_letter: expected %0d, got %0d", due.letter, out_letter);
                    error_count++;
                end
                if (last_of_pair !== due.last)
                begin
                    $error("last_of_pair: expected %0b, got %0b", due.last, last_of_pair);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        push         = 1'b0;
        cmd          = CMD_KEY;
        letter       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        error_count  = 0;
        stall_cycles = 0;
        // Predictor starts from the reset state: empty square, encrypt mode.
        for (int k = 0; k < LETTERS; k++)
        begin
            letter_placed[k]  = 1'b0;
            square_cell_of[k] = '0;
        end
        for (int k = 0; k < CELLS; k++)
            key_square[k] = '0;
        square_fill  = 0;
        held_letter  = '0;
        held_valid   = 1'b0;
        mode_encrypt = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_square();
        test_pair_rules();
        test_random_messages();

        push <= 1'b0;
        while (cipher_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
